// ----- design/aavr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aavr_pkg
// Shared types, angle constants and the CORDIC arctangent table for the
// axis-angle vector rotation block.
// ----------------------------------------------------------------------------
package aavr_pkg;

  // Angle handling, in 1/128 degree steps.
  localparam int ANG_W       = 18;
  localparam int DEG_HALF    = 180;
  localparam int ANG_STEPS   = 128;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(DEG_HALF * ANG_STEPS);
  localparam logic signed [ANG_W-1:0] FULL_TURN    = ANG_W'(2 * DEG_HALF * ANG_STEPS);
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(DEG_HALF * ANG_STEPS / 2);

  // CORDIC datapath widths: x/y in Q2.30 with headroom, z in 2^-16 degree.
  localparam int XW = 34;
  localparam int ZW = 25;
  localparam int CORDIC_INV_GAIN = 652032874;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec3_t;

  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
  } axis3_t;

  // atan(2^-i) in 2^-16 degree units, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
    logic signed [ZW-1:0] val;
    unique case (idx)
      5'd0:  val = ZW'(2949120);
      5'd1:  val = ZW'(1740967);
      5'd2:  val = ZW'(919879);
      5'd3:  val = ZW'(466945);
      5'd4:  val = ZW'(234379);
      5'd5:  val = ZW'(117304);
      5'd6:  val = ZW'(58666);
      5'd7:  val = ZW'(29335);
      5'd8:  val = ZW'(14668);
      5'd9:  val = ZW'(7334);
      5'd10: val = ZW'(3667);
      5'd11: val = ZW'(1833);
      5'd12: val = ZW'(917);
      5'd13: val = ZW'(458);
      5'd14: val = ZW'(229);
      5'd15: val = ZW'(115);
      5'd16: val = ZW'(57);
      5'd17: val = ZW'(29);
      5'd18: val = ZW'(14);
      5'd19: val = ZW'(7);
      5'd20: val = ZW'(4);
      5'd21: val = ZW'(2);
      5'd22: val = ZW'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// ----- design/axis_angle_vector_rotate.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate
// Rotates a Q16.16 vector about a unit axis by an angle, using a CORDIC for
// cosine and sine and the Rodrigues rotation matrix.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while out_tready is high; the CORDIC and
// matrix pipelines are fully pipelined and a 4-entry queue lets front and
// back stall separately.
// Reset: synchronous, active low; clears valid flags, queue pointers and fill count only.
// No state carries from one item to the next.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotate import aavr_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS     = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // vec_x[31:0], vec_y[63:32], vec_z[95:64], axis_x[113:96],
  // axis_y[131:114], axis_z[149:132], angle_deg[166:150], zero pad[167]
  input  wire logic [167:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [95:0]       out_tdata,
  // saturated[0]
  output logic [0:0]        out_tuser
);

  localparam int CSW = FRAC_BITS + 3;
  localparam int QW  = 96 + 54 + 2 * CSW;

  vec3_t                 in_vec, f_vec, b_vec, o_vec;
  axis3_t                in_axis, f_axis, b_axis;
  logic signed [CSW-1:0] f_cos, f_sin, b_cos, b_sin;
  logic                  f_valid, q_full, q_empty, q_push, q_pop, o_sat;
  logic [QW-1:0]         q_din, q_dout;

  // Unpack the input item.
  assign in_vec.x  = in_tdata[31:0];
  assign in_vec.y  = in_tdata[63:32];
  assign in_vec.z  = in_tdata[95:64];
  assign in_axis.x = in_tdata[113:96];
  assign in_axis.y = in_tdata[131:114];
  assign in_axis.z = in_tdata[149:132];

  aavr_front #(
    .CORDIC_STAGES (CORDIC_STAGES),
    .FRAC_BITS     (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_vec    (in_vec),
    .in_axis   (in_axis),
    .in_angle  (in_tdata[166:150]),
    .out_valid (f_valid),
    .out_full  (q_full),
    .out_vec   (f_vec),
    .out_axis  (f_axis),
    .out_cos   (f_cos),
    .out_sin   (f_sin)
  );

  // Queue between CORDIC front and matrix back.
  assign q_push = f_valid && !q_full;
  assign q_din  = {f_sin, f_cos, f_axis, f_vec};

  aavr_fifo #(
    .W     (QW),
    .PTR_W (2)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  assign b_vec  = q_dout[95:0];
  assign b_axis = q_dout[149:96];
  assign b_cos  = q_dout[150 +: CSW];
  assign b_sin  = q_dout[150 + CSW +: CSW];

  aavr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_avail  (!q_empty),
    .in_pop    (q_pop),
    .in_vec    (b_vec),
    .in_axis   (b_axis),
    .in_cos    (b_cos),
    .in_sin    (b_sin),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_vec   (o_vec),
    .out_sat   (o_sat)
  );

  // Pack the result item.
  assign out_tdata = {o_vec.z, o_vec.y, o_vec.x};
  assign out_tuser = o_sat;

endmodule
`default_nettype wire

// ----- design/aavr_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aavr_fifo
// Small register queue that decouples the CORDIC front from the matrix back.
// ----------------------------------------------------------------------------
module aavr_fifo #(
  parameter int W      = 8,
  parameter int PTR_W  = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  input  wire logic         pop,
  output logic      [W-1:0] dout,
  output logic              full,
  output logic              empty
);

  localparam int DEPTH = 1 << PTR_W;

  logic [W-1:0]     mem_r [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full  = (count_r == (PTR_W+1)'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PTR_W+1)'(DEPTH))
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ----- design/aavr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aavr_front
// Reduces the angle to [-90, 90] degrees, runs a pipelined CORDIC and rounds
// cosine and sine to the output fraction width.
// ----------------------------------------------------------------------------
module aavr_front import aavr_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS     = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire vec3_t                       in_vec,
  input  wire axis3_t                      in_axis,
  input  wire logic signed [16:0]          in_angle,
  output logic                             out_valid,
  input  wire logic                        out_full,
  output vec3_t                            out_vec,
  output axis3_t                           out_axis,
  output logic signed [FRAC_BITS+2:0]      out_cos,
  output logic signed [FRAC_BITS+2:0]      out_sin
);

  localparam int NS  = CORDIC_STAGES;
  localparam int CSW = FRAC_BITS + 3;
  localparam int SH  = 30 - FRAC_BITS;

  logic [NS+1:0]          valid_r;
  logic signed [XW-1:0]   x_r [0:NS];
  logic signed [XW-1:0]   y_r [0:NS];
  logic signed [ZW-1:0]   z_r [0:NS];
  logic                   flip_r [0:NS];
  vec3_t                  vec_r [0:NS+1];
  axis3_t                 axis_r [0:NS+1];
  logic signed [CSW-1:0]  cos_r, sin_r;
  logic                   en;

  // The whole front advances unless its last item cannot enter the queue.
  assign en        = !valid_r[NS+1] || !out_full;
  assign in_ready  = en;
  assign out_valid = valid_r[NS+1];
  assign out_vec   = vec_r[NS+1];
  assign out_axis  = axis_r[NS+1];
  assign out_cos   = cos_r;
  assign out_sin   = sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[NS:0], in_valid};
    end
  end

  // Angle reduction: modulo a full turn, into [-180, 180), then fold to
  // [-90, 90] with a flag that negates cosine and sine afterwards.
  logic signed [ANG_W-1:0] a0, a1, a2, a3;
  logic                    flip;

  always_comb begin
    a0 = {in_angle[16], in_angle};
    a1 = a0;
    if (a0 >= FULL_TURN) begin
      a1 = ANG_W'(a0 - FULL_TURN);
    end else if (a0 < 0) begin
      a1 = ANG_W'(a0 + FULL_TURN);
      if (a1 < 0) a1 = ANG_W'(a1 + FULL_TURN);
    end
    a2 = (a1 >= HALF_TURN) ? ANG_W'(a1 - FULL_TURN) : a1;
    a3   = a2;
    flip = 1'b0;
    if (a2 > QUARTER_TURN) begin
      a3   = ANG_W'(a2 - HALF_TURN);
      flip = 1'b1;
    end else if (a2 < -QUARTER_TURN) begin
      a3   = ANG_W'(a2 + HALF_TURN);
      flip = 1'b1;
    end
  end

  // Stage zero: load the CORDIC start point.
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= XW'(CORDIC_INV_GAIN);
      y_r[0]    <= '0;
      z_r[0]    <= {a3[15:0], 9'b0};
      flip_r[0] <= flip;
      vec_r[0]  <= in_vec;
      axis_r[0] <= in_axis;
    end
  end

  // One CORDIC micro-rotation per stage.
  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic signed [XW-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - atan_q16(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + atan_q16(5'(i));
        end
        flip_r[i+1] <= flip_r[i];
        vec_r[i+1]  <= vec_r[i];
        axis_r[i+1] <= axis_r[i];
      end
    end
  end

  // Undo the fold and round from Q2.30 to the output fraction width.
  logic signed [XW-1:0] xf, yf, xr, yr;

  always_comb begin
    xf = flip_r[NS] ? -x_r[NS] : x_r[NS];
    yf = flip_r[NS] ? -y_r[NS] : y_r[NS];
    xr = xf + (XW'(1) <<< (SH - 1));
    yr = yf + (XW'(1) <<< (SH - 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r        <= CSW'(xr >>> SH);
      sin_r        <= CSW'(yr >>> SH);
      vec_r[NS+1]  <= vec_r[NS];
      axis_r[NS+1] <= axis_r[NS];
    end
  end

endmodule
`default_nettype wire

// ----- design/aavr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aavr_back
// Builds the Rodrigues matrix from cosine, sine and the axis, multiplies it
// by the vector and rounds and saturates the result.
// ----------------------------------------------------------------------------
module aavr_back import aavr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_avail,
  output logic                         in_pop,
  input  wire vec3_t                   in_vec,
  input  wire axis3_t                  in_axis,
  input  wire logic signed [FRAC_BITS+2:0] in_cos,
  input  wire logic signed [FRAC_BITS+2:0] in_sin,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output vec3_t                        out_vec,
  output logic                         out_sat
);

  localparam int CSW = FRAC_BITS + 3;
  localparam int SAW = 18 + CSW;
  localparam int PW  = 36 + CSW;
  localparam int RW  = FRAC_BITS + 6;
  localparam int MW  = RW + 32;
  localparam int AW  = MW + 2;
  localparam logic signed [AW-1:0] MAXV = AW'(64'sd2147483647);
  localparam logic signed [AW-1:0] MINV = AW'(-64'sd2147483648);

  logic [4:0] vld_r;
  logic       en;

  // Stall only when the output register holds an item nobody takes.
  assign en        = !vld_r[4] || out_ready;
  assign in_pop    = en && in_avail;
  assign out_valid = vld_r[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_avail};
    end
  end

  // Stage 1: axis products, axis times sine, and 1 - cos.
  logic signed [35:0]     aa_r [0:5];
  logic signed [SAW-1:0]  as_r [0:2];
  logic signed [CSW-1:0]  c1_r, t1_r;
  vec3_t                  v1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      aa_r[0] <= in_axis.x * in_axis.x;
      aa_r[1] <= in_axis.y * in_axis.y;
      aa_r[2] <= in_axis.z * in_axis.z;
      aa_r[3] <= in_axis.x * in_axis.y;
      aa_r[4] <= in_axis.x * in_axis.z;
      aa_r[5] <= in_axis.y * in_axis.z;
      as_r[0] <= in_axis.x * in_sin;
      as_r[1] <= in_axis.y * in_sin;
      as_r[2] <= in_axis.z * in_sin;
      c1_r    <= in_cos;
      t1_r    <= (CSW'(1) <<< FRAC_BITS) - in_cos;
      v1_r    <= in_vec;
    end
  end

  // Stage 2: scale axis products by 1 - cos and round both term groups.
  logic signed [PW-1:0]  pt [0:5];
  logic signed [RW-1:0]  q_r [0:5];
  logic signed [RW-1:0]  sq_r [0:2];
  logic signed [RW-1:0]  c2_r;
  vec3_t                 v2_r;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      pt[k] = aa_r[k] * t1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        q_r[k] <= RW'((pt[k] + (PW'(1) <<< 31)) >>> 32);
      end
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= RW'((as_r[k] + (SAW'(1) <<< 15)) >>> 16);
      end
      c2_r <= RW'(c1_r);
      v2_r <= v1_r;
    end
  end

  // Stage 3: assemble the nine matrix entries, row major.
  logic signed [RW-1:0] r_r [0:8];
  vec3_t                v3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0] <= q_r[0] + c2_r;
      r_r[1] <= q_r[3] - sq_r[2];
      r_r[2] <= q_r[4] + sq_r[1];
      r_r[3] <= q_r[3] + sq_r[2];
      r_r[4] <= q_r[1] + c2_r;
      r_r[5] <= q_r[5] - sq_r[0];
      r_r[6] <= q_r[4] - sq_r[1];
      r_r[7] <= q_r[5] + sq_r[0];
      r_r[8] <= q_r[2] + c2_r;
      v3_r   <= v2_r;
    end
  end

  // Stage 4: matrix times vector, one product per entry.
  logic signed [MW-1:0] m_r [0:8];
  logic signed [31:0]   vc [0:2];

  assign vc[0] = v3_r.x;
  assign vc[1] = v3_r.y;
  assign vc[2] = v3_r.z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        m_r[k] <= r_r[k] * vc[k % 3];
      end
    end
  end

  // Stage 5: row sums, rounding and saturation into the output register.
  logic signed [AW-1:0] acc [0:2];
  logic signed [AW-1:0] rnd [0:2];
  logic signed [31:0]   res [0:2];
  logic [2:0]           clip;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = AW'(m_r[3*i]) + AW'(m_r[3*i+1]) + AW'(m_r[3*i+2]);
      rnd[i] = (acc[i] + (AW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      clip[i] = 1'b1;
      if (rnd[i] > MAXV)      res[i] = 32'sh7fffffff;
      else if (rnd[i] < MINV) res[i] = 32'sh80000000;
      else begin
        res[i]  = 32'(rnd[i]);
        clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec.x <= res[0];
      out_vec.y <= res[1];
      out_vec.z <= res[2];
      out_sat   <= |clip;
    end
  end

  a_sat_means_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sat) |->
      (out_vec.x == 32'sh7fffffff || out_vec.x == 32'sh80000000 ||
       out_vec.y == 32'sh7fffffff || out_vec.y == 32'sh80000000 ||
       out_vec.z == 32'sh7fffffff || out_vec.z == 32'sh80000000))
    else $error("saturated flag without a clipped component");
  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    in_pop |=> vld_r[0])
    else $error("popped item did not enter the matrix pipeline");

endmodule
`default_nettype wire
